/* hdl/lccl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccl_pkg
// Shared constants and codes for the linked cell list binner.
// ----------------------------------------------------------------------------
package lccl_pkg;

  localparam int unsigned LCCL_MAX_POINTS = 4096;
  localparam int unsigned LCCL_MAX_CELLS  = 4096;

  localparam int COORD_W = 32;
  localparam int COUNT_W = 5;
  localparam int PNUM_W  = 12;
  localparam int CELL_W  = 12;
  localparam int LINK_W  = 13;
  localparam int FLAT_W  = 17;

  localparam logic [LINK_W-1:0] LINK_EMPTY = '1;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  localparam logic [1:0] REG_CELL_WIDTH = 2'd0;
  localparam logic [1:0] REG_CELLS_X    = 2'd1;
  localparam logic [1:0] REG_CELLS_Y    = 2'd2;
  localparam logic [1:0] REG_CELLS_Z    = 2'd3;

  // memory word: valid flag over the head point number
  typedef struct packed {
    logic              valid;
    logic [PNUM_W-1:0] head;
  } head_entry_t;

endpackage
`default_nettype wire

/* hdl/lccl_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccl_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lccl_div
  import lccl_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic [COORD_W-1:0] dividend,
  input  wire logic [COORD_W-1:0] divisor,
  output logic      [COORD_W-1:0] quotient,
  output logic                    done
);

  localparam int CNT_W = $clog2(COORD_W + 1);

  logic [COORD_W:0]   rem;
  logic [CNT_W-1:0]   cnt;
  logic [COORD_W:0]   shifted;
  logic [COORD_W:0]   diff;

  assign shifted = {rem[COORD_W-1:0], quotient[COORD_W-1]};
  assign diff    = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        cnt <= CNT_W'(COORD_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (cnt != '0) begin
      if (!diff[COORD_W]) begin
        rem      <= diff;
        quotient <= {quotient[COORD_W-2:0], 1'b1};
      end else begin
        rem      <= shifted;
        quotient <= {quotient[COORD_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/lccl_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lccl_mem
// Head table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lccl_mem
  import lccl_pkg::*;
#(
  parameter int unsigned DEPTH = LCCL_MAX_CELLS,
  parameter int          AW    = $clog2(DEPTH)
) (
  input  wire logic        clk,
  input  wire logic        we,
  input  wire logic [AW-1:0] waddr,
  input  wire head_entry_t wdata,
  input  wire logic        re,
  input  wire logic [AW-1:0] raddr,
  output head_entry_t      rdata
);

  head_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/linked_cell_list_binner_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linked_cell_list_binner_core
// Bins 3-D points into cubic cells and keeps a head-linked list per cell.
//
// A request is taken when start is high and busy is low. Every request gives
// one result on cell_number/link/out_of_range, marked by done for one cycle;
// the receiver cannot stall it.
// Insert: three bit-serial dividers find the cell coordinates, S_DIV waits
// until all three finish, then S_CALC forms the flat index and reads the
// head table, and S_LOOK returns the old head and writes the new one; when
// the cell lies outside the grid, S_CALC gives the result instead.
// Read: table read, then result; an index beyond the table is refused at once.
// No operation: the result comes at once. Clear: the result comes at once,
// then a sweep writes every table entry, during which busy stays high.
// Reset runs the same sweep before the first request is taken. Registers may
// be written through wr_en/wr_index/wr_data at any time the block is idle.
// ----------------------------------------------------------------------------
module linked_cell_list_binner_core
  import lccl_pkg::*;
#(
  parameter int unsigned MAX_POINTS = LCCL_MAX_POINTS,
  parameter int unsigned MAX_CELLS  = LCCL_MAX_CELLS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [1:0]         wr_index,
  input  wire logic [COORD_W-1:0] wr_data,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         action,
  input  wire logic [PNUM_W-1:0]  point_number,
  input  wire logic [COORD_W-1:0] coord_x,
  input  wire logic [COORD_W-1:0] coord_y,
  input  wire logic [COORD_W-1:0] coord_z,
  input  wire logic [CELL_W-1:0]  query_cell,
  output logic                    done,
  output logic [CELL_W-1:0]       cell_number,
  output logic signed [LINK_W-1:0] link,
  output logic                    out_of_range
);

  localparam int AW = $clog2(MAX_CELLS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_LOOK = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;

  logic [2:0]            state;
  logic [COORD_W-1:0]    cell_width;
  logic [COUNT_W-1:0]    cells_x, cells_y, cells_z;
  logic [2*COUNT_W-1:0]  cells_xy;
  logic [PNUM_W-1:0]     pnum;
  logic                  is_insert;
  logic [AW-1:0]         addr;
  logic [CELL_W-1:0]     cell_q;
  logic [AW-1:0]         clr_cnt;

  logic [COORD_W-1:0]    qx, qy, qz;
  logic                  dx, dy, dz;
  logic                  accept;

  logic [FLAT_W-1:0]     flat;
  logic                  grid_bad;
  logic [FLAT_W-1:0]     query_ext;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  head_entry_t           mem_wdata, mem_rdata;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_width <= COORD_W'(65536);
      cells_x    <= COUNT_W'(16);
      cells_y    <= COUNT_W'(16);
      cells_z    <= COUNT_W'(16);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CELL_WIDTH: cell_width <= wr_data;
        REG_CELLS_X:    cells_x    <= wr_data[COUNT_W-1:0];
        REG_CELLS_Y:    cells_y    <= wr_data[COUNT_W-1:0];
        REG_CELLS_Z:    cells_z    <= wr_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // settles long before the dividers finish
  always_ff @(posedge clk) begin
    cells_xy <= cells_x * cells_y;
  end

  lccl_div u_div_x (.clk, .rst, .go(accept && action == ACT_INSERT), .dividend(coord_x),
                    .divisor(cell_width), .quotient(qx), .done(dx));
  lccl_div u_div_y (.clk, .rst, .go(accept && action == ACT_INSERT), .dividend(coord_y),
                    .divisor(cell_width), .quotient(qy), .done(dy));
  lccl_div u_div_z (.clk, .rst, .go(accept && action == ACT_INSERT), .dividend(coord_z),
                    .divisor(cell_width), .quotient(qz), .done(dz));

  assign flat = FLAT_W'(qx[COUNT_W-1:0])
              + FLAT_W'(qy[COUNT_W-1:0]) * FLAT_W'(cells_x)
              + FLAT_W'(qz[COUNT_W-1:0]) * FLAT_W'(cells_xy);

  assign grid_bad = (cell_width == '0)
                 || (qx >= COORD_W'(cells_x))
                 || (qy >= COORD_W'(cells_y))
                 || (qz >= COORD_W'(cells_z))
                 || (FLAT_W'(pnum) >= FLAT_W'(MAX_POINTS))
                 || (flat >= FLAT_W'(MAX_CELLS));

  assign query_ext = FLAT_W'(query_cell);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = query_ext[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = '{valid: 1'b1, head: pnum};
    unique case (state)
      S_IDLE: mem_re = accept && action == ACT_READ && query_ext < FLAT_W'(MAX_CELLS);
      S_CALC: begin
        mem_re    = !grid_bad;
        mem_raddr = flat[AW-1:0];
      end
      S_LOOK: mem_we = is_insert;
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '{valid: 1'b0, head: '0};
      end
      default: ;
    endcase
  end

  lccl_mem #(.DEPTH(MAX_CELLS), .AW(AW)) u_mem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (action)
              ACT_INSERT: state <= S_DIV;
              ACT_READ: begin
                if (query_ext < FLAT_W'(MAX_CELLS)) state <= S_LOOK;
                else done <= 1'b1;
              end
              ACT_CLEAR: begin
                done    <= 1'b1;
                clr_cnt <= '0;
                state   <= S_CLR;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_DIV: if (dx && dy && dz) state <= S_CALC;
        S_CALC: begin
          if (grid_bad) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(MAX_CELLS - 1)) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // request fields and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pnum      <= point_number;
      is_insert <= (action == ACT_INSERT);
      cell_q    <= query_cell;
      addr      <= query_ext[AW-1:0];
    end else if (state == S_CALC) begin
      addr   <= flat[AW-1:0];
      cell_q <= flat[CELL_W-1:0];
    end

    if (accept) begin
      cell_number  <= (action == ACT_READ) ? query_cell : '0;
      link         <= LINK_EMPTY;
      out_of_range <= (action == ACT_READ) && !(query_ext < FLAT_W'(MAX_CELLS));
    end else if (state == S_CALC) begin
      cell_number  <= '0;
      link         <= LINK_EMPTY;
      out_of_range <= 1'b1;
    end else if (state == S_LOOK) begin
      cell_number  <= cell_q;
      link         <= mem_rdata.valid ? LINK_W'(mem_rdata.head) : LINK_EMPTY;
      out_of_range <= 1'b0;
    end
  end

  a_oor_empty: assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> link == LINK_EMPTY)
    else $error("refused request carries a link");

  a_insert_busy: assert property (@(posedge clk) disable iff (rst)
    accept && action == ACT_INSERT |=> busy && !done)
    else $error("insert finished too early");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !mem_we)
    else $error("table written while idle");

endmodule
`default_nettype wire
